// ===== hw/rtl/gap_pkg.sv =====
// Shared types, constants and helper functions of the grid A* path searcher.
package gap_pkg;

  // Grid geometry; the coordinate fields are six bits wide.
  localparam int COORD_W = 6;
  localparam int GRID_W  = 64;
  localparam int GRID_H  = 64;
  localparam int NCELLS  = GRID_W * GRID_H;
  localparam int IDX_W   = 12;
  localparam int LEN_W   = 13;
  localparam int DIM_W   = 7;
  localparam int G_W     = 16;
  localparam int H_W     = 11;
  localparam int F_W     = 17;
  localparam int COST_W  = 8;
  localparam int EXP_W   = 16;
  localparam int CFG_W   = 16;
  localparam int CFG_IDX_W = 2;

  // Move costs: straight 1.0 and diagonal 1.4, scaled by ten.
  localparam logic [F_W-1:0] STEP_STRAIGHT = F_W'(10);
  localparam logic [F_W-1:0] STEP_DIAG     = F_W'(14);
  localparam logic [G_W-1:0] G_MAX         = '1;

  // Input operation codes.
  localparam logic [1:0] MODE_WRITE  = 2'd0;
  localparam logic [1:0] MODE_SEARCH = 2'd1;
  localparam logic [1:0] MODE_READ   = 2'd2;

  // Result status codes.
  localparam logic [1:0] STAT_OK     = 2'd0;
  localparam logic [1:0] STAT_NOPATH = 2'd1;
  localparam logic [1:0] STAT_NOTIME = 2'd2;
  localparam logic [1:0] STAT_BEYOND = 2'd3;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAP_W     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MAP_H     = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_EXP   = 2'd3;

  // Per-cell search state held in one memory word.
  typedef struct packed {
    logic           open;
    logic           closed;
    logic [G_W-1:0] g;
    logic [2:0]     dir;
  } st_word_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_RD_WAIT, ST_CLEAR, ST_INIT, ST_SCAN, ST_DECIDE, ST_NB_RD,
    ST_NB_CHK, ST_P1_RD, ST_P1_STEP, ST_P2_WR, ST_P2_STEP, ST_DONE
  } fsm_t;

  // Column offset of a move direction, as a seven-bit two's complement value.
  function automatic logic [DIM_W-1:0] dir_dx(input logic [2:0] d);
    logic [DIM_W-1:0] r;
    case (d)
      3'd0, 3'd1, 3'd2: r = '1;
      3'd3, 3'd4:       r = '0;
      default:          r = DIM_W'(1);
    endcase
    return r;
  endfunction

  // Row offset of a move direction, as a seven-bit two's complement value.
  function automatic logic [DIM_W-1:0] dir_dy(input logic [2:0] d);
    logic [DIM_W-1:0] r;
    case (d)
      3'd0, 3'd3, 3'd5: r = '1;
      3'd1, 3'd6:       r = '0;
      default:          r = DIM_W'(1);
    endcase
    return r;
  endfunction

  function automatic logic is_diag(input logic [2:0] d);
    return (dir_dx(d) != '0) && (dir_dy(d) != '0);
  endfunction

  // Cell that a move in direction d came from.
  function automatic logic [IDX_W-1:0] parent_of(input logic [IDX_W-1:0] c,
                                                 input logic [2:0] d);
    logic [DIM_W-1:0]   dx;
    logic [DIM_W-1:0]   dy;
    logic [COORD_W-1:0] px;
    logic [COORD_W-1:0] py;
    dx = dir_dx(d);
    dy = dir_dy(d);
    px = c[COORD_W-1:0] - dx[COORD_W-1:0];
    py = c[IDX_W-1:COORD_W] - dy[COORD_W-1:0];
    return {py, px};
  endfunction

  function automatic logic [COORD_W-1:0] absdiff(input logic [COORD_W-1:0] a,
                                                 input logic [COORD_W-1:0] b);
    return (a > b) ? a - b : b - a;
  endfunction

  // Ten times the Manhattan distance from cell c to the goal.
  function automatic logic [H_W-1:0] heur(input logic [IDX_W-1:0] c,
                                          input logic [COORD_W-1:0] gx,
                                          input logic [COORD_W-1:0] gy);
    logic [DIM_W-1:0] s;
    s = {1'b0, absdiff(c[COORD_W-1:0], gx)} + {1'b0, absdiff(c[IDX_W-1:COORD_W], gy)};
    return ({4'b0, s} << 3) + ({4'b0, s} << 1);
  endfunction

endpackage

// ===== hw/rtl/gap_in_if.sv =====
// Input channel of the path searcher: handshake and item fields.
interface gap_in_if;
  import gap_pkg::*;
  logic               valid;
  logic               ready;
  logic [1:0]         mode;
  logic [COORD_W-1:0] cell_x;
  logic [COORD_W-1:0] cell_y;
  logic [COST_W-1:0]  cell_cost;
  logic [COORD_W-1:0] start_x;
  logic [COORD_W-1:0] start_y;
  logic [COORD_W-1:0] goal_x;
  logic [COORD_W-1:0] goal_y;
  logic [IDX_W-1:0]   path_index;

  modport source (output valid, mode, cell_x, cell_y, cell_cost, start_x, start_y,
                  goal_x, goal_y, path_index, input ready);
  modport sink (input valid, mode, cell_x, cell_y, cell_cost, start_x, start_y,
                goal_x, goal_y, path_index, output ready);
endinterface

// ===== hw/rtl/gap_out_if.sv =====
// Result channel of the path searcher: handshake and result fields.
interface gap_out_if;
  import gap_pkg::*;
  logic               valid;
  logic               ready;
  logic [1:0]         status;
  logic [LEN_W-1:0]   path_length;
  logic [COORD_W-1:0] path_x;
  logic [COORD_W-1:0] path_y;

  modport source (output valid, status, path_length, path_x, path_y, input ready);
  modport sink (input valid, status, path_length, path_x, path_y, output ready);
endinterface

// ===== hw/rtl/grid_astar_path_search.sv =====
// Map writes, unused codes and reads beyond the path are answered from the idle state; path reads
// first wait for the registered path memory. One item at a time. A search clears the cell state
// memory, then per expansion scans the open window of the state memory (one cell a cycle, lowest
// to highest opened index) and checks eight neighbors, reading memory only for those inside the
// map; path building walks back from the goal twice, first counting the cells, then storing them.
// Reset (synchronous, active low) restores the configuration registers and clears control state;
// the memories need no clearing pass, since each search clears its own marks.
module grid_astar_path_search
  import gap_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  gap_in_if.sink               in_ch,
  gap_out_if.source            out_ch,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_wdata
);

  fsm_t state_r, state_nxt;
  logic [COST_W-1:0]  thr_r;
  logic [DIM_W-1:0]   mw_r, mh_r;
  logic [EXP_W-1:0]   mx_r;
  logic [LEN_W-1:0]   found_len_r, found_len_nxt;
  logic [1:0]         sstat_r, sstat_nxt;
  logic               out_v_r, out_v_nxt;
  logic [1:0]         out_status_r, out_status_nxt;
  logic [LEN_W-1:0]   out_len_r, out_len_nxt;
  logic [COORD_W-1:0] out_x_r, out_x_nxt, out_y_r, out_y_nxt;
  logic [IDX_W-1:0]   si_r, si_nxt;
  logic [COORD_W-1:0] gx_r, gx_nxt, gy_r, gy_nxt;
  logic [EXP_W-1:0]   cnt_r, cnt_nxt;
  logic [IDX_W-1:0]   lo_r, lo_nxt, hi_r, hi_nxt;
  logic [IDX_W-1:0]   sa_r, sa_nxt;
  logic               idone_r, idone_nxt;
  logic               pv_r, pv_nxt;
  logic [IDX_W-1:0]   pa_r, pa_nxt;
  logic               any_r, any_nxt;
  logic [IDX_W-1:0]   best_r, best_nxt;
  logic [F_W-1:0]     best_f_r, best_f_nxt;
  st_word_t           best_w_r, best_w_nxt;
  logic [2:0]         dir_r, dir_nxt;
  logic [IDX_W-1:0]   cur_r, cur_nxt;
  logic [LEN_W-1:0]   len_r, len_nxt;
  logic [IDX_W-1:0]   nb_r, nb_nxt;

  // Memory ports.
  logic              cost_we;
  logic [IDX_W-1:0]  cost_waddr, cost_raddr;
  logic [COST_W-1:0] cost_wdata, cost_rdata;
  logic              st_we;
  logic [IDX_W-1:0]  st_waddr, st_raddr;
  st_word_t          st_wdata, st_rdata;
  logic              path_we;
  logic [IDX_W-1:0]  path_waddr, path_raddr, path_rdata, path_wdata;

  logic [DIM_W-1:0] ew, eh;
  logic             in_xfer;
  logic [DIM_W-1:0] nx7, ny7;
  logic [F_W-1:0]   scan_f, ng17;
  logic [G_W-1:0]   ngs;

  gap_ram #(.WIDTH(COST_W), .DEPTH(NCELLS)) u_cost_ram (
    .clk(clk), .we(cost_we), .waddr(cost_waddr), .wdata(cost_wdata),
    .raddr(cost_raddr), .rdata(cost_rdata)
  );

  gap_ram #(.WIDTH($bits(st_word_t)), .DEPTH(NCELLS)) u_state_ram (
    .clk(clk), .we(st_we), .waddr(st_waddr), .wdata(st_wdata),
    .raddr(st_raddr), .rdata(st_rdata)
  );

  gap_ram #(.WIDTH(IDX_W), .DEPTH(NCELLS)) u_path_ram (
    .clk(clk), .we(path_we), .waddr(path_waddr), .wdata(path_wdata),
    .raddr(path_raddr), .rdata(path_rdata)
  );

  // Map size in use, capped at the grid.
  assign ew = (mw_r > DIM_W'(GRID_W)) ? DIM_W'(GRID_W) : mw_r;
  assign eh = (mh_r > DIM_W'(GRID_H)) ? DIM_W'(GRID_H) : mh_r;

  assign in_ch.ready    = (state_r == ST_IDLE) && (!out_v_r || out_ch.ready);
  assign in_xfer        = in_ch.valid && in_ch.ready;
  assign out_ch.valid   = out_v_r;
  assign out_ch.status  = out_status_r;
  assign out_ch.path_length = out_len_r;
  assign out_ch.path_x  = out_x_r;
  assign out_ch.path_y  = out_y_r;

  // Neighbor coordinates and candidate cost.
  assign nx7    = {1'b0, best_r[COORD_W-1:0]} + dir_dx(dir_r);
  assign ny7    = {1'b0, best_r[IDX_W-1:COORD_W]} + dir_dy(dir_r);
  assign ng17   = {1'b0, best_w_r.g} + (is_diag(dir_r) ? STEP_DIAG : STEP_STRAIGHT);
  assign ngs    = ng17[F_W-1] ? G_MAX : ng17[G_W-1:0];
  assign scan_f = {1'b0, st_rdata.g} + F_W'(heur(pa_r, gx_r, gy_r));

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r <= COST_W'(253);
      mw_r  <= DIM_W'(64);
      mh_r  <= DIM_W'(64);
      mx_r  <= EXP_W'(5000);
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_THRESHOLD: thr_r <= cfg_wdata[COST_W-1:0];
        CFG_MAP_W:     mw_r  <= cfg_wdata[DIM_W-1:0];
        CFG_MAP_H:     mh_r  <= cfg_wdata[DIM_W-1:0];
        CFG_MAX_EXP:   mx_r  <= cfg_wdata[EXP_W-1:0];
        default: ;
      endcase
    end
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      found_len_r <= '0;
      sstat_r     <= STAT_NOPATH;
      out_v_r     <= 1'b0;
      idone_r     <= 1'b0;
      pv_r        <= 1'b0;
      any_r       <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      found_len_r <= found_len_nxt;
      sstat_r     <= sstat_nxt;
      out_v_r     <= out_v_nxt;
      idone_r     <= idone_nxt;
      pv_r        <= pv_nxt;
      any_r       <= any_nxt;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    out_status_r <= out_status_nxt;
    out_len_r    <= out_len_nxt;
    out_x_r      <= out_x_nxt;
    out_y_r      <= out_y_nxt;
    si_r         <= si_nxt;
    gx_r         <= gx_nxt;
    gy_r         <= gy_nxt;
    cnt_r        <= cnt_nxt;
    lo_r         <= lo_nxt;
    hi_r         <= hi_nxt;
    sa_r         <= sa_nxt;
    pa_r         <= pa_nxt;
    best_r       <= best_nxt;
    best_f_r     <= best_f_nxt;
    best_w_r     <= best_w_nxt;
    dir_r        <= dir_nxt;
    cur_r        <= cur_nxt;
    len_r        <= len_nxt;
    nb_r         <= nb_nxt;
  end

  // Sequencer: next state, memory accesses and result loading.
  always_comb begin
    state_nxt      = state_r;
    found_len_nxt  = found_len_r;
    sstat_nxt      = sstat_r;
    out_v_nxt      = out_v_r && !out_ch.ready;
    out_status_nxt = out_status_r;
    out_len_nxt    = out_len_r;
    out_x_nxt      = out_x_r;
    out_y_nxt      = out_y_r;
    si_nxt         = si_r;
    gx_nxt         = gx_r;
    gy_nxt         = gy_r;
    cnt_nxt        = cnt_r;
    lo_nxt         = lo_r;
    hi_nxt         = hi_r;
    sa_nxt         = sa_r;
    idone_nxt      = idone_r;
    pv_nxt         = 1'b0;
    pa_nxt         = pa_r;
    any_nxt        = any_r;
    best_nxt       = best_r;
    best_f_nxt     = best_f_r;
    best_w_nxt     = best_w_r;
    dir_nxt        = dir_r;
    cur_nxt        = cur_r;
    len_nxt        = len_r;
    nb_nxt         = nb_r;
    cost_we        = 1'b0;
    cost_waddr     = {in_ch.cell_y, in_ch.cell_x};
    cost_wdata     = in_ch.cell_cost;
    cost_raddr     = nb_r;
    st_we          = 1'b0;
    st_waddr       = best_r;
    st_wdata       = '0;
    st_raddr       = cur_r;
    path_we        = 1'b0;
    path_waddr     = '0;
    path_wdata     = cur_r;
    path_raddr     = in_ch.path_index;

    unique case (state_r)
      ST_IDLE: begin
        if (in_xfer) begin
          out_status_nxt = STAT_OK;
          out_len_nxt    = found_len_r;
          out_x_nxt      = '0;
          out_y_nxt      = '0;
          case (in_ch.mode)
            MODE_WRITE: begin
              cost_we   = 1'b1;
              out_v_nxt = 1'b1;
            end
            MODE_SEARCH: begin
              found_len_nxt = '0;
              gx_nxt        = in_ch.goal_x;
              gy_nxt        = in_ch.goal_y;
              si_nxt        = {in_ch.start_y, in_ch.start_x};
              if ({1'b0, in_ch.start_x} >= ew || {1'b0, in_ch.start_y} >= eh) begin
                sstat_nxt = STAT_NOPATH;
                state_nxt = ST_DONE;
              end else begin
                sa_nxt    = '0;
                state_nxt = ST_CLEAR;
              end
            end
            MODE_READ: begin
              if ({1'b0, in_ch.path_index} < found_len_r) begin
                state_nxt = ST_RD_WAIT;
              end else begin
                out_status_nxt = STAT_BEYOND;
                out_v_nxt      = 1'b1;
              end
            end
            default: out_v_nxt = 1'b1;
          endcase
        end
      end

      ST_RD_WAIT: begin
        out_v_nxt      = 1'b1;
        out_x_nxt      = path_rdata[COORD_W-1:0];
        out_y_nxt      = path_rdata[IDX_W-1:COORD_W];
        state_nxt      = ST_IDLE;
      end

      // Clear open and closed marks of every cell.
      ST_CLEAR: begin
        st_we    = 1'b1;
        st_waddr = sa_r;
        sa_nxt   = sa_r + 1'b1;
        if (&sa_r) begin
          state_nxt = ST_INIT;
        end
      end

      // Open the start cell with zero cost.
      ST_INIT: begin
        st_we         = 1'b1;
        st_waddr      = si_r;
        st_wdata.open = 1'b1;
        lo_nxt        = si_r;
        hi_nxt        = si_r;
        cnt_nxt       = '0;
        sa_nxt        = si_r;
        idone_nxt     = 1'b0;
        any_nxt       = 1'b0;
        state_nxt     = ST_SCAN;
      end

      // Stream the open window and keep the least f, first index on ties.
      ST_SCAN: begin
        st_raddr = sa_r;
        if (!idone_r) begin
          pv_nxt = 1'b1;
          pa_nxt = sa_r;
          if (sa_r == hi_r) begin
            idone_nxt = 1'b1;
          end else begin
            sa_nxt = sa_r + 1'b1;
          end
        end
        if (pv_r && st_rdata.open && (!any_r || scan_f < best_f_r)) begin
          any_nxt    = 1'b1;
          best_nxt   = pa_r;
          best_f_nxt = scan_f;
          best_w_nxt = st_rdata;
        end
        if (idone_r && !pv_r) begin
          state_nxt = ST_DECIDE;
        end
      end

      // Stop or close the chosen cell.
      ST_DECIDE: begin
        if (!any_r) begin
          sstat_nxt = STAT_NOPATH;
          state_nxt = ST_DONE;
        end else if (cnt_r >= mx_r) begin
          sstat_nxt = STAT_NOTIME;
          state_nxt = ST_DONE;
        end else begin
          cnt_nxt         = cnt_r + 1'b1;
          st_we           = 1'b1;
          st_waddr        = best_r;
          st_wdata        = best_w_r;
          st_wdata.open   = 1'b0;
          st_wdata.closed = 1'b1;
          if (best_r == {gy_r, gx_r}) begin
            cur_nxt   = best_r;
            len_nxt   = LEN_W'(1);
            state_nxt = ST_P1_RD;
          end else begin
            dir_nxt   = '0;
            state_nxt = ST_NB_RD;
          end
        end
      end

      // Fetch a neighbor inside the map.
      ST_NB_RD: begin
        if (nx7 < ew && ny7 < eh) begin
          nb_nxt     = {ny7[COORD_W-1:0], nx7[COORD_W-1:0]};
          cost_raddr = {ny7[COORD_W-1:0], nx7[COORD_W-1:0]};
          st_raddr   = {ny7[COORD_W-1:0], nx7[COORD_W-1:0]};
          state_nxt  = ST_NB_CHK;
        end else if (dir_r == 3'd7) begin
          sa_nxt    = lo_r;
          idone_nxt = 1'b0;
          any_nxt   = 1'b0;
          state_nxt = ST_SCAN;
        end else begin
          dir_nxt = dir_r + 1'b1;
        end
      end

      // Relax the neighbor if it is free, not closed and improved.
      ST_NB_CHK: begin
        if (cost_rdata < thr_r && !st_rdata.closed &&
            (!st_rdata.open || ngs < st_rdata.g)) begin
          st_we         = 1'b1;
          st_waddr      = nb_r;
          st_wdata.open = 1'b1;
          st_wdata.g    = ngs;
          st_wdata.dir  = dir_r;
          if (nb_r < lo_r) begin
            lo_nxt = nb_r;
          end
          if (nb_r > hi_r) begin
            hi_nxt = nb_r;
          end
        end
        if (dir_r == 3'd7) begin
          sa_nxt    = lo_r;
          if (st_we && nb_r < lo_r) begin
            sa_nxt = nb_r;
          end
          idone_nxt = 1'b0;
          any_nxt   = 1'b0;
          state_nxt = ST_SCAN;
        end else begin
          dir_nxt   = dir_r + 1'b1;
          state_nxt = ST_NB_RD;
        end
      end

      // First walk back from the goal: count the path cells.
      ST_P1_RD: begin
        if (cur_r == si_r || len_r == LEN_W'(NCELLS)) begin
          found_len_nxt = len_r;
          cur_nxt       = {gy_r, gx_r};
          state_nxt     = ST_P2_WR;
        end else begin
          st_raddr  = cur_r;
          state_nxt = ST_P1_STEP;
        end
      end

      ST_P1_STEP: begin
        cur_nxt   = parent_of(cur_r, st_rdata.dir);
        len_nxt   = len_r + 1'b1;
        state_nxt = ST_P1_RD;
      end

      // Second walk: store the path cells from the end toward the start.
      ST_P2_WR: begin
        path_we    = 1'b1;
        path_waddr = len_r[IDX_W-1:0] - 1'b1;
        if (len_r == LEN_W'(1)) begin
          sstat_nxt = STAT_OK;
          state_nxt = ST_DONE;
        end else begin
          st_raddr  = cur_r;
          state_nxt = ST_P2_STEP;
        end
      end

      ST_P2_STEP: begin
        cur_nxt   = parent_of(cur_r, st_rdata.dir);
        len_nxt   = len_r - 1'b1;
        state_nxt = ST_P2_WR;
      end

      ST_DONE: begin
        out_v_nxt      = 1'b1;
        out_status_nxt = sstat_r;
        out_len_nxt    = found_len_r;
        out_x_nxt      = '0;
        out_y_nxt      = '0;
        state_nxt      = ST_IDLE;
      end

      default: state_nxt = ST_IDLE;
    endcase
  end

  // An item is only taken while the sequencer is idle.
  a_accept_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer |-> (state_r == ST_IDLE))
    else $error("input transfer outside idle");

  // The scan never writes the state memory.
  a_scan_no_write: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SCAN) |-> !st_we)
    else $error("state memory written during scan");

  // A map write gives its result on the next cycle.
  a_write_result: assert property (@(posedge clk) disable iff (!rst_n)
    (in_xfer && in_ch.mode == MODE_WRITE) |=> out_v_r)
    else $error("map write gave no result");

  // The found length never exceeds the grid.
  a_len_bound: assert property (@(posedge clk) disable iff (!rst_n)
    found_len_r <= LEN_W'(NCELLS))
    else $error("found length out of range");

endmodule

// ===== hw/rtl/gap_ram.sv =====
// Generic simple dual-port RAM with one write port and a registered read port.
module gap_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// ===== sim/testbench.sv =====
// Testbench for the grid A* path searcher: directed rows, then random phases checked by a predictor.
`timescale 1ns / 1ps

module testbench;
  import gap_pkg::*;

  // Unused operation code; the block answers it without doing anything.
  localparam logic [1:0] MODE_NONE = 2'd3;
  localparam int IDLE_LIMIT = 400000;
  localparam int ITEM_GOAL  = 1950;

  typedef struct {
    logic [1:0]         mode;
    logic [COORD_W-1:0] cell_x;
    logic [COORD_W-1:0] cell_y;
    logic [COST_W-1:0]  cell_cost;
    logic [COORD_W-1:0] start_x;
    logic [COORD_W-1:0] start_y;
    logic [COORD_W-1:0] goal_x;
    logic [COORD_W-1:0] goal_y;
    logic [IDX_W-1:0]   path_index;
  } item_t;

  typedef struct {
    logic [1:0]         status;
    logic [LEN_W-1:0]   path_length;
    logic [COORD_W-1:0] path_x;
    logic [COORD_W-1:0] path_y;
  } result_t;

  typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_t;

  typedef struct {
    row_kind_t            kind;
    item_t                it;
    logic [CFG_IDX_W-1:0] reg_idx;
    logic [CFG_W-1:0]     reg_val;
    bit                   typed;
    result_t              res;
  } row_t;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]     cfg_wdata;

  gap_in_if  in_ch();
  gap_out_if out_ch();

  grid_astar_path_search u_top (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  // Predictor state: map, search bookkeeping, last path and registers.
  bit [7:0]       cost_mem [NCELLS];
  bit [15:0]      g_mem    [NCELLS];
  bit [2:0]       dir_mem  [NCELLS];
  bit             open_mem [NCELLS];
  bit             closed_mem [NCELLS];
  bit [11:0]      route_mem [NCELLS];
  int unsigned    route_len;
  bit [1:0]       last_status;
  bit [7:0]       thr_reg;
  bit [6:0]       width_reg;
  bit [6:0]       height_reg;
  bit [15:0]      exp_reg;

  const int DX[8] = '{-1, -1, -1, 0, 0, 1, 1, 1};
  const int DY[8] = '{-1, 0, 1, -1, 1, -1, 0, 1};

  result_t pending_results[$];
  int error_count;
  int items_sent;
  int results_seen;
  int search_hits[4];
  int idle_cycles;
  bit calm;

  // Prints one line per mismatch and counts every one.
  task automatic report_mismatch(string what, int got, int want);
    error_count++;
    $display("%0t mismatch %s: got %0d expected %0d", $time, what, got, want);
  endtask

  function automatic int step_back(int c);
    int d;
    d = dir_mem[c];
    return (c / GRID_W - DY[d]) * GRID_W + (c % GRID_W - DX[d]);
  endfunction

  function automatic int manhattan10(int x, int y, int gx, int gy);
    return 10 * (((x > gx) ? x - gx : gx - x) + ((y > gy) ? y - gy : gy - y));
  endfunction

  // A* over the predictor's map; sets last_status and the path.
  task automatic plan_path(int sx, int sy, int gx, int gy);
    int ew, eh, cnt, si, best, bestf, f, bx, by, nx, ny, ni, ng, n, c;
    bit any;
    ew = (width_reg < GRID_W) ? width_reg : GRID_W;
    eh = (height_reg < GRID_H) ? height_reg : GRID_H;
    cnt = 0;
    for (int i = 0; i < NCELLS; i++) begin
      open_mem[i] = 0;
      closed_mem[i] = 0;
    end
    route_len = 0;
    if (sx >= ew || sy >= eh) begin
      last_status = STAT_NOPATH;
      return;
    end
    si = sy * GRID_W + sx;
    g_mem[si] = 0;
    dir_mem[si] = 0;
    open_mem[si] = 1;
    forever begin
      any = 0;
      best = 0;
      bestf = 0;
      for (int i = 0; i < NCELLS; i++) begin
        if (open_mem[i]) begin
          f = g_mem[i] + manhattan10(i % GRID_W, i / GRID_W, gx, gy);
          if (!any || f < bestf) begin
            any = 1;
            best = i;
            bestf = f;
          end
        end
      end
      if (!any) begin
        last_status = STAT_NOPATH;
        return;
      end
      if (cnt >= exp_reg) begin
        last_status = STAT_NOTIME;
        return;
      end
      cnt++;
      open_mem[best] = 0;
      closed_mem[best] = 1;
      bx = best % GRID_W;
      by = best / GRID_W;
      if (bx == gx && by == gy) begin
        // Walk the parent links back to the start, then store start first.
        n = 1;
        c = best;
        while (c != si && n < NCELLS) begin
          c = step_back(c);
          n++;
        end
        route_len = n;
        c = best;
        for (int k = n; k > 0; k--) begin
          route_mem[k-1] = 12'(c);
          if (k > 1) c = step_back(c);
        end
        last_status = STAT_OK;
        return;
      end
      for (int d = 0; d < 8; d++) begin
        nx = bx + DX[d];
        ny = by + DY[d];
        if (nx < 0 || ny < 0 || nx >= ew || ny >= eh) continue;
        ni = ny * GRID_W + nx;
        if (cost_mem[ni] >= thr_reg || closed_mem[ni]) continue;
        ng = g_mem[best] + ((DX[d] != 0 && DY[d] != 0) ? 14 : 10);
        if (ng > 65535) ng = 65535;
        if (!open_mem[ni] || ng < g_mem[ni]) begin
          open_mem[ni] = 1;
          g_mem[ni] = 16'(ng);
          dir_mem[ni] = 3'(d);
        end
      end
    end
  endtask

  // Expected result of one accepted item, updating the predictor state.
  task automatic apply_item(item_t it, output result_t r);
    r = '{STAT_OK, '0, '0, '0};
    case (it.mode)
      MODE_WRITE: cost_mem[{it.cell_y, it.cell_x}] = it.cell_cost;
      MODE_SEARCH: begin
        plan_path(it.start_x, it.start_y, it.goal_x, it.goal_y);
        r.status = last_status;
        search_hits[last_status]++;
      end
      MODE_READ: begin
        if (it.path_index < route_len) begin
          r.path_x = route_mem[it.path_index][5:0];
          r.path_y = route_mem[it.path_index][11:6];
        end else begin
          r.status = STAT_BEYOND;
        end
      end
      default: ;
    endcase
    r.path_length = route_len[LEN_W-1:0];
  endtask

  function automatic int pick_gap();
    int p;
    if (calm) return 0;
    p = $urandom_range(0, 99);
    if (p < 65) return 0;
    if (p < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Offers one item and waits for its transfer; the expectation is queued on accept.
  task automatic send_item(item_t it, bit typed, result_t res);
    int gap;
    result_t r;
    gap = pick_gap();
    if (gap > 0) begin
      @(negedge clk);
      in_ch.valid = 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_ch.valid = 1'b1;
    in_ch.mode = it.mode;
    in_ch.cell_x = it.cell_x;
    in_ch.cell_y = it.cell_y;
    in_ch.cell_cost = it.cell_cost;
    in_ch.start_x = it.start_x;
    in_ch.start_y = it.start_y;
    in_ch.goal_x = it.goal_x;
    in_ch.goal_y = it.goal_y;
    in_ch.path_index = it.path_index;
    do @(posedge clk); while (!in_ch.ready);
    apply_item(it, r);
    pending_results.insert(pending_results.size(), typed ? res : r);
    items_sent++;
  endtask

  task automatic wait_idle();
    @(negedge clk);
    in_ch.valid = 1'b0;
    while (pending_results.size() > 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  // Register write while the block is idle; the predictor follows it.
  task automatic set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
    wait_idle();
    @(negedge clk);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_wdata = val;
    @(negedge clk);
    cfg_we = 1'b0;
    case (idx)
      CFG_THRESHOLD: thr_reg = val[7:0];
      CFG_MAP_W:     width_reg = val[6:0];
      CFG_MAP_H:     height_reg = val[6:0];
      default:       exp_reg = val;
    endcase
  endtask

  // Item with every field random; callers then set the fields that matter.
  function automatic item_t rand_item(logic [1:0] mode);
    item_t it;
    it.mode = mode;
    it.cell_x = COORD_W'($urandom);
    it.cell_y = COORD_W'($urandom);
    it.cell_cost = COST_W'($urandom);
    it.start_x = COORD_W'($urandom);
    it.start_y = COORD_W'($urandom);
    it.goal_x = COORD_W'($urandom);
    it.goal_y = COORD_W'($urandom);
    it.path_index = IDX_W'($urandom);
    return it;
  endfunction

  function automatic row_t write_row(int x, int y, int c);
    row_t r;
    r.kind = ROW_ITEM;
    r.typed = 0;
    r.it = rand_item(MODE_WRITE);
    r.it.cell_x = COORD_W'(x);
    r.it.cell_y = COORD_W'(y);
    r.it.cell_cost = COST_W'(c);
    return r;
  endfunction

  function automatic row_t search_row(int sx, int sy, int gx, int gy);
    row_t r;
    r.kind = ROW_ITEM;
    r.typed = 0;
    r.it = rand_item(MODE_SEARCH);
    r.it.start_x = COORD_W'(sx);
    r.it.start_y = COORD_W'(sy);
    r.it.goal_x = COORD_W'(gx);
    r.it.goal_y = COORD_W'(gy);
    return r;
  endfunction

  function automatic row_t read_row(int k);
    row_t r;
    r.kind = ROW_ITEM;
    r.typed = 0;
    r.it = rand_item(MODE_READ);
    r.it.path_index = IDX_W'(k);
    return r;
  endfunction

  function automatic row_t cfg_row(logic [CFG_IDX_W-1:0] idx, int val);
    row_t r;
    r.kind = ROW_CFG;
    r.typed = 0;
    r.reg_idx = idx;
    r.reg_val = CFG_W'(val);
    return r;
  endfunction

  function automatic row_t with_res(row_t r, logic [1:0] st, int len, int x, int y);
    r.typed = 1;
    r.res = '{st, LEN_W'(len), COORD_W'(x), COORD_W'(y)};
    return r;
  endfunction

  // Clock.
  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Result side: random stalls, with calm stretches of full throughput.
  int stall_left;
  always @(negedge clk) begin
    if (calm || !rst_n) begin
      out_ch.ready = 1'b1;
    end else if (stall_left > 0) begin
      out_ch.ready = 1'b0;
      stall_left--;
    end else begin
      out_ch.ready = 1'b1;
      if ($urandom_range(0, 99) < 25)
        stall_left = ($urandom_range(0, 19) == 0) ? $urandom_range(20, 80) : $urandom_range(1, 3);
    end
  end

  // Result checking against the oldest expectation.
  always @(posedge clk) begin
    result_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      results_seen++;
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected result, status", out_ch.status, -1);
      end else begin
        want = pending_results.pop_front();
        if (out_ch.status !== want.status)
          report_mismatch("status", out_ch.status, want.status);
        if (out_ch.path_length !== want.path_length)
          report_mismatch("path_length", out_ch.path_length, want.path_length);
        if (out_ch.path_x !== want.path_x)
          report_mismatch("path_x", out_ch.path_x, want.path_x);
        if (out_ch.path_y !== want.path_y)
          report_mismatch("path_y", out_ch.path_y, want.path_y);
      end
    end
  end

  // Watchdog on cycles with no transfer on either channel.
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      idle_cycles = 0;
    end else if (rst_n) begin
      idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("timeout after %0d cycles without a transfer", idle_cycles);
        $display("== FAIL ==");
        $finish;
      end
    end
  end

  // Stimulus.
  initial begin
    row_t dir_rows[$];
    item_t it;
    result_t none;
    int w, h, p, len;
    none = '{STAT_OK, '0, '0, '0};
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_wdata = '0;
    in_ch.valid = 1'b0;
    in_ch.mode = MODE_WRITE;
    in_ch.cell_x = '0;
    in_ch.cell_y = '0;
    in_ch.cell_cost = '0;
    in_ch.start_x = '0;
    in_ch.start_y = '0;
    in_ch.goal_x = '0;
    in_ch.goal_y = '0;
    in_ch.path_index = '0;
    out_ch.ready = 1'b1;
    calm = 1'b0;
    stall_left = 0;
    error_count = 0;
    items_sent = 0;
    results_seen = 0;
    idle_cycles = 0;
    thr_reg = 253;
    width_reg = 64;
    height_reg = 64;
    exp_reg = 5000;
    route_len = 0;
    last_status = STAT_NOPATH;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Fill every cell that any search below can touch.
    calm = 1'b1;
    for (int y = 0; y < 8; y++)
      for (int x = 0; x < 8; x++) begin
        it = rand_item(MODE_WRITE);
        it.cell_x = COORD_W'(x);
        it.cell_y = COORD_W'(y);
        it.cell_cost = ($urandom_range(0, 9) == 0) ? 8'd255 : 8'($urandom_range(0, 150));
        send_item(it, 0, none);
      end
    calm = 1'b0;

    // Directed rows: reset state, a big-map corner, small maps and limits.
    dir_rows.insert(dir_rows.size(), with_res(read_row(0), STAT_BEYOND, 0, 0, 0));
    dir_rows.insert(dir_rows.size(), with_res(read_row(4095), STAT_BEYOND, 0, 0, 0));
    begin
      row_t r;
      r = read_row(0);
      r.it.mode = MODE_NONE;
      dir_rows.insert(dir_rows.size(), with_res(r, STAT_OK, 0, 0, 0));
    end
    dir_rows.insert(dir_rows.size(), with_res(write_row(62, 62, 0), STAT_OK, 0, 0, 0));
    dir_rows.insert(dir_rows.size(), with_res(write_row(63, 62, 255), STAT_OK, 0, 0, 0));
    dir_rows.insert(dir_rows.size(), with_res(write_row(62, 63, 255), STAT_OK, 0, 0, 0));
    dir_rows.insert(dir_rows.size(), with_res(write_row(63, 63, 0), STAT_OK, 0, 0, 0));
    dir_rows.insert(dir_rows.size(), with_res(search_row(63, 63, 62, 62), STAT_OK, 2, 0, 0));
    dir_rows.insert(dir_rows.size(), with_res(read_row(0), STAT_OK, 2, 63, 63));
    dir_rows.insert(dir_rows.size(), with_res(read_row(1), STAT_OK, 2, 62, 62));
    dir_rows.insert(dir_rows.size(), with_res(read_row(2), STAT_BEYOND, 2, 0, 0));
    dir_rows.insert(dir_rows.size(), cfg_row(CFG_MAP_W, 4));
    dir_rows.insert(dir_rows.size(), cfg_row(CFG_MAP_H, 3));
    dir_rows.insert(dir_rows.size(), cfg_row(CFG_THRESHOLD, 200));
    dir_rows.insert(dir_rows.size(), cfg_row(CFG_MAX_EXP, 65535));
    dir_rows.insert(dir_rows.size(), with_res(search_row(4, 0, 0, 0), STAT_NOPATH, 0, 0, 0));
    dir_rows.insert(dir_rows.size(), write_row(0, 0, 0));
    dir_rows.insert(dir_rows.size(), search_row(0, 0, 3, 2));
    dir_rows.insert(dir_rows.size(), read_row(0));
    dir_rows.insert(dir_rows.size(), read_row(3));
    dir_rows.insert(dir_rows.size(), write_row(3, 2, 255));
    dir_rows.insert(dir_rows.size(), search_row(0, 0, 3, 2));
    dir_rows.insert(dir_rows.size(), cfg_row(CFG_MAX_EXP, 0));
    dir_rows.insert(dir_rows.size(), with_res(search_row(0, 0, 1, 1), STAT_NOTIME, 0, 0, 0));
    dir_rows.insert(dir_rows.size(), cfg_row(CFG_MAX_EXP, 1));
    dir_rows.insert(dir_rows.size(), with_res(search_row(0, 0, 0, 0), STAT_OK, 1, 0, 0));
    dir_rows.insert(dir_rows.size(), search_row(0, 0, 1, 0));
    dir_rows.insert(dir_rows.size(), cfg_row(CFG_THRESHOLD, 0));
    dir_rows.insert(dir_rows.size(), cfg_row(CFG_MAX_EXP, 5000));
    dir_rows.insert(dir_rows.size(), with_res(search_row(1, 1, 2, 1), STAT_NOPATH, 0, 0, 0));
    dir_rows.insert(dir_rows.size(), cfg_row(CFG_THRESHOLD, 255));
    dir_rows.insert(dir_rows.size(), cfg_row(CFG_MAP_W, 1));
    dir_rows.insert(dir_rows.size(), cfg_row(CFG_MAP_H, 1));
    dir_rows.insert(dir_rows.size(), with_res(search_row(0, 0, 0, 0), STAT_OK, 1, 0, 0));
    dir_rows.insert(dir_rows.size(), with_res(search_row(0, 1, 0, 0), STAT_NOPATH, 0, 0, 0));
    foreach (dir_rows[i]) begin
      if (dir_rows[i].kind == ROW_CFG)
        set_reg(dir_rows[i].reg_idx, dir_rows[i].reg_val);
      else
        send_item(dir_rows[i].it, dir_rows[i].typed, dir_rows[i].res);
    end

    // Random phases: new registers, then writes, searches with path reads, and noise.
    while (items_sent < ITEM_GOAL) begin
      p = $urandom_range(0, 9);
      w = (p == 0) ? 1 : (p == 1) ? 8 : $urandom_range(2, 8);
      p = $urandom_range(0, 9);
      h = (p == 0) ? 1 : (p == 1) ? 8 : $urandom_range(2, 8);
      set_reg(CFG_MAP_W, CFG_W'(w));
      set_reg(CFG_MAP_H, CFG_W'(h));
      p = $urandom_range(0, 9);
      set_reg(CFG_THRESHOLD, CFG_W'((p == 0) ? 0 : (p == 1) ? 255 : (p < 5) ? 253 :
                                    $urandom_range(1, 254)));
      p = $urandom_range(0, 19);
      set_reg(CFG_MAX_EXP, CFG_W'((p == 0) ? 0 : (p == 1) ? 1 : (p < 4) ? 65535 :
                                  (p < 7) ? $urandom_range(1, 10) : $urandom_range(11, 200)));
      calm = ($urandom_range(0, 3) == 0);
      for (int n = 0; n < 60 && items_sent < ITEM_GOAL; n++) begin
        p = $urandom_range(0, 99);
        if (p < 50) begin
          it = rand_item(MODE_WRITE);
          if ($urandom_range(0, 4) != 0) begin
            it.cell_x = COORD_W'($urandom_range(0, 7));
            it.cell_y = COORD_W'($urandom_range(0, 7));
          end
          if ($urandom_range(0, 2) == 0) it.cell_cost = COST_W'($urandom_range(0, 20));
          send_item(it, 0, none);
        end else if (p < 60) begin
          it = rand_item(MODE_SEARCH);
          if ($urandom_range(0, 9) != 0) begin
            it.start_x = COORD_W'($urandom_range(0, w - 1));
            it.start_y = COORD_W'($urandom_range(0, h - 1));
          end
          if ($urandom_range(0, 6) != 0) begin
            it.goal_x = COORD_W'($urandom_range(0, w - 1));
            it.goal_y = COORD_W'($urandom_range(0, h - 1));
          end
          send_item(it, 0, none);
          len = route_len;
          for (int k = 0; k <= len; k++) begin
            it = rand_item(MODE_READ);
            it.path_index = IDX_W'(k);
            send_item(it, 0, none);
          end
        end else if (p < 64) begin
          send_item(rand_item(MODE_NONE), 0, none);
        end else begin
          it = rand_item(MODE_READ);
          if ($urandom_range(0, 1) == 0)
            it.path_index = IDX_W'($urandom_range(0, route_len + 1));
          send_item(it, 0, none);
        end
      end
    end

    wait_idle();
    repeat (20) @(posedge clk);
    $display("items %0d, results %0d; searches found %0d, no path %0d, out of expansions %0d",
             items_sent, results_seen, search_hits[STAT_OK], search_hits[STAT_NOPATH],
             search_hits[STAT_NOTIME]);
    $display("mismatches %0d, results still expected %0d", error_count,
             pending_results.size());
    if (error_count == 0 && pending_results.size() == 0)
      $display("== PASS ==");
    else
      $display("== FAIL ==");
    $finish;
  end

endmodule

// ===== sim.f =====
hw/rtl/gap_pkg.sv
hw/rtl/gap_in_if.sv
hw/rtl/gap_out_if.sv
hw/rtl/gap_ram.sv
hw/rtl/grid_astar_path_search.sv
sim/testbench.sv
